>>> hdl/dfsd_pkg.sv
// ----------------------------------------------------------------------------
// Dual format serial deframer package
// Shared result type, status codes and defaults for the deframer.
// ----------------------------------------------------------------------------
package dfsd_pkg;

  // default frame length limit for DLE-delimited frames
  localparam int MAX_DLE_FRAME_DEF = 256;

  // frame kinds
  localparam logic KIND_PREAMBLE = 1'b0;
  localparam logic KIND_DLE      = 1'b1;

  // closing status codes
  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_BAD_CHECK = 2'd1,
    ST_SHORT     = 2'd2,
    ST_ABANDON   = 2'd3
  } status_e;

  // one result item
  typedef struct packed {
    logic        frame_kind;
    logic [7:0]  dest_addr;
    logic [7:0]  source_addr;
    logic [7:0]  command;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  payload_len;
    logic        end_of_frame;
    status_e     frame_status;
  } result_t;

endpackage

>>> hdl/dual_format_serial_deframer_core.sv
// A result is registered in the output stage by the byte transfer that causes it.
// Throughput: one byte per cycle while in_ready_o is high; the parser state updates once per accepted byte.
// A two-entry output stage (register plus skid) keeps input ready up while one result waits.
// Reset (rst_ni low, asynchronous) returns the parser to hunting and empties the output stage.
// ----------------------------------------------------------------------------
// Dual format serial deframer
// Recognizes preamble frames with a 16-bit sum and DLE-delimited frames with
// an 8-bit sum; emits one result per payload byte and a closing status.
// ----------------------------------------------------------------------------
module dual_format_serial_deframer_core #(
  parameter int MAX_DLE_FRAME = dfsd_pkg::MAX_DLE_FRAME_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       frame_kind_o,
  output logic [7:0] dest_addr_o,
  output logic [7:0] source_addr_o,
  output logic [7:0] command_o,
  output logic [7:0] payload_byte_o,
  output logic [7:0] payload_index_o,
  output logic [7:0] payload_len_o,
  output logic       end_of_frame_o,
  output logic [1:0] frame_status_o
);
  import dfsd_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res, out_res;

  assign accept = in_valid_i && in_ready_o;

  // frame parser
  dfsd_parser #(
    .MAX_DLE_FRAME(MAX_DLE_FRAME)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output register and skid entry
  dfsd_out_skid u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept && res_valid),
    .push_data_i  (res),
    .push_ready_o (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_res)
  );

  assign frame_kind_o    = out_res.frame_kind;
  assign dest_addr_o     = out_res.dest_addr;
  assign source_addr_o   = out_res.source_addr;
  assign command_o       = out_res.command;
  assign payload_byte_o  = out_res.payload_byte;
  assign payload_index_o = out_res.payload_index;
  assign payload_len_o   = out_res.payload_len;
  assign end_of_frame_o  = out_res.end_of_frame;
  assign frame_status_o  = out_res.frame_status;

endmodule

>>> hdl/dfsd_parser.sv
// ----------------------------------------------------------------------------
// Deframer parser
// Frame state machine: consumes one byte per transfer and forms at most one
// result from the current state and that byte.
// ----------------------------------------------------------------------------
module dfsd_parser #(
  parameter int MAX_DLE_FRAME = dfsd_pkg::MAX_DLE_FRAME_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  output logic              res_valid_o,
  output dfsd_pkg::result_t res_o
);
  import dfsd_pkg::*;

  localparam logic [9:0] LimitLen = 10'(MAX_DLE_FRAME);

  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_A5  = 8'hA5;
  localparam logic [7:0] BYTE_DLE = 8'h10;
  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_ETX = 8'h03;
  localparam logic [23:0] PREAMBLE_HEAD = 24'hFF00FF;

  typedef enum logic [9:0] {
    PH_HUNT = 10'b00_0000_0001,
    PH_VER  = 10'b00_0000_0010,
    PH_DST  = 10'b00_0000_0100,
    PH_SRC  = 10'b00_0000_1000,
    PH_CMD  = 10'b00_0001_0000,
    PH_LEN  = 10'b00_0010_0000,
    PH_DATA = 10'b00_0100_0000,
    PH_CKHI = 10'b00_1000_0000,
    PH_CKLO = 10'b01_0000_0000,
    PH_BODY = 10'b10_0000_0000
  } phase_e;

  // saturate a 9-bit count to one byte
  function automatic logic [7:0] sat8(input logic [8:0] v);
    sat8 = v[8] ? BYTE_FF : v[7:0];
  endfunction

  phase_e      phase_q, phase_d;
  logic [23:0] recent_q, recent_d;
  logic [7:0]  hold_dest_q, hold_dest_d;
  logic [7:0]  hold_source_q, hold_source_d;
  logic [7:0]  hold_command_q, hold_command_d;
  logic [7:0]  declared_len_q, declared_len_d;
  logic [8:0]  byte_count_q, byte_count_d;
  logic [15:0] running_sum_q, running_sum_d;
  logic [7:0]  check_high_q, check_high_d;
  logic [15:0] delay_q, delay_d;
  logic [1:0]  delay_fill_q, delay_fill_d;

  logic [7:0]  newer, older;
  logic [8:0]  cnt_inc, before_close, popped, pos;
  logic        res_kind;

  assign newer   = delay_q[7:0];
  assign older   = delay_q[15:8];
  assign cnt_inc = byte_count_q + 9'd1;
  assign before_close = byte_count_q - 9'd1;
  assign popped  = byte_count_q - {7'd0, delay_fill_q};
  assign pos     = cnt_inc - 9'd2;

  // next state and result
  always_comb begin
    phase_d        = phase_q;
    recent_d       = recent_q;
    hold_dest_d    = hold_dest_q;
    hold_source_d  = hold_source_q;
    hold_command_d = hold_command_q;
    declared_len_d = declared_len_q;
    byte_count_d   = byte_count_q;
    running_sum_d  = running_sum_q;
    check_high_d   = check_high_q;
    delay_d        = delay_q;
    delay_fill_d   = delay_fill_q;
    res_valid_o    = 1'b0;
    res_kind       = KIND_PREAMBLE;
    res_o          = '0;

    if (accept_i) begin
      case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == BYTE_A5 && recent_q == PREAMBLE_HEAD) begin
            phase_d        = PH_VER;
            running_sum_d  = 16'(BYTE_A5);
            hold_dest_d    = '0;
            hold_source_d  = '0;
            hold_command_d = '0;
            declared_len_d = '0;
            byte_count_d   = '0;
            check_high_d   = '0;
          end else if (rx_byte_i == BYTE_STX && recent_q[7:0] == BYTE_DLE) begin
            phase_d        = PH_BODY;
            running_sum_d  = 16'(BYTE_DLE) + 16'(BYTE_STX);
            hold_dest_d    = '0;
            hold_source_d  = '0;
            hold_command_d = '0;
            byte_count_d   = '0;
            delay_d        = '0;
            delay_fill_d   = '0;
          end else begin
            recent_d = {recent_q[15:0], rx_byte_i};
          end
        end
        PH_VER: begin
          running_sum_d = running_sum_q + 16'(rx_byte_i);
          phase_d       = PH_DST;
        end
        PH_DST: begin
          running_sum_d = running_sum_q + 16'(rx_byte_i);
          hold_dest_d   = rx_byte_i;
          phase_d       = PH_SRC;
        end
        PH_SRC: begin
          running_sum_d = running_sum_q + 16'(rx_byte_i);
          hold_source_d = rx_byte_i;
          phase_d       = PH_CMD;
        end
        PH_CMD: begin
          running_sum_d  = running_sum_q + 16'(rx_byte_i);
          hold_command_d = rx_byte_i;
          phase_d        = PH_LEN;
        end
        PH_LEN: begin
          running_sum_d  = running_sum_q + 16'(rx_byte_i);
          declared_len_d = rx_byte_i;
          byte_count_d   = '0;
          phase_d        = (rx_byte_i == 8'd0) ? PH_CKHI : PH_DATA;
        end
        PH_DATA: begin
          running_sum_d = running_sum_q + 16'(rx_byte_i);
          byte_count_d  = cnt_inc;
          if (cnt_inc >= {1'b0, declared_len_q}) begin
            phase_d = PH_CKHI;
          end
          res_valid_o         = 1'b1;
          res_o.payload_byte  = rx_byte_i;
          res_o.payload_index = byte_count_q[7:0];
          res_o.payload_len   = sat8(cnt_inc);
        end
        PH_CKHI: begin
          check_high_d = rx_byte_i;
          phase_d      = PH_CKLO;
        end
        PH_CKLO: begin
          phase_d            = PH_HUNT;
          recent_d           = '0;
          res_valid_o        = 1'b1;
          res_o.end_of_frame = 1'b1;
          res_o.payload_len  = declared_len_q;
          res_o.frame_status = ({check_high_q, rx_byte_i} == running_sum_q) ?
                               ST_GOOD : ST_BAD_CHECK;
        end
        PH_BODY: begin
          res_kind = KIND_DLE;
          if (rx_byte_i == BYTE_ETX && delay_fill_q != 2'd0 && newer == BYTE_DLE) begin
            // closing DLE ETX: check byte sits in the older delay slot
            phase_d            = PH_HUNT;
            recent_d           = '0;
            res_valid_o        = 1'b1;
            res_o.end_of_frame = 1'b1;
            if (before_close < 9'd3) begin
              res_o.frame_status = ST_SHORT;
            end else begin
              res_o.payload_len  = sat8(before_close - 9'd3);
              res_o.frame_status = (running_sum_q[7:0] == older) ? ST_GOOD : ST_BAD_CHECK;
            end
          end else if (({1'b0, byte_count_q} + 10'd3) >= LimitLen) begin
            // length limit reached: drop the frame
            phase_d            = PH_HUNT;
            recent_d           = '0;
            res_valid_o        = 1'b1;
            res_o.end_of_frame = 1'b1;
            res_o.frame_status = ST_ABANDON;
            res_o.payload_len  = (popped > 9'd2) ? sat8(popped - 9'd2) : 8'd0;
          end else begin
            byte_count_d = cnt_inc;
            if (cnt_inc == 9'd1) begin
              hold_dest_d = rx_byte_i;
            end else if (cnt_inc == 9'd2) begin
              hold_command_d = rx_byte_i;
            end
            // two-byte delay line; popped bytes join the sum
            if (delay_fill_q >= 2'd2) begin
              running_sum_d = running_sum_q + 16'(older);
              delay_d       = {newer, rx_byte_i};
              if (pos >= 9'd3) begin
                res_valid_o         = 1'b1;
                res_o.payload_byte  = older;
                res_o.payload_index = 8'(pos - 9'd3);
                res_o.payload_len   = sat8(pos - 9'd2);
              end
            end else begin
              delay_d      = {delay_q[7:0], rx_byte_i};
              delay_fill_d = delay_fill_q + 2'd1;
            end
          end
        end
        default: begin
          phase_d  = PH_HUNT;
          recent_d = '0;
        end
      endcase
    end

    // header fields as held after this byte
    res_o.frame_kind  = res_kind;
    res_o.dest_addr   = hold_dest_d;
    res_o.source_addr = (res_kind == KIND_DLE) ? 8'd0 : hold_source_d;
    res_o.command     = hold_command_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HUNT;
      recent_q       <= '0;
      hold_dest_q    <= '0;
      hold_source_q  <= '0;
      hold_command_q <= '0;
      declared_len_q <= '0;
      byte_count_q   <= '0;
      running_sum_q  <= '0;
      check_high_q   <= '0;
      delay_q        <= '0;
      delay_fill_q   <= '0;
    end else begin
      phase_q        <= phase_d;
      recent_q       <= recent_d;
      hold_dest_q    <= hold_dest_d;
      hold_source_q  <= hold_source_d;
      hold_command_q <= hold_command_d;
      declared_len_q <= declared_len_d;
      byte_count_q   <= byte_count_d;
      running_sum_q  <= running_sum_d;
      check_high_q   <= check_high_d;
      delay_q        <= delay_d;
      delay_fill_q   <= delay_fill_d;
    end
  end

endmodule

>>> hdl/dfsd_out_skid.sv
// ----------------------------------------------------------------------------
// Deframer output stage
// Output register plus one skid entry; upstream ready is registered.
// ----------------------------------------------------------------------------
module dfsd_out_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dfsd_pkg::result_t push_data_i,
  output logic              push_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dfsd_pkg::result_t out_data_o
);
  import dfsd_pkg::*;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    out_take;

  assign out_take     = out_valid_q && out_ready_i;
  assign push_ready_o = !skid_valid_q;
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (out_take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= push_data_i;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_q <= push_data_i;
      end else begin
        out_q <= push_data_i;
      end
    end
  end

endmodule
